// File: rtl/bf_pkg.sv
// Shared types, constants and the round function of the Blowfish engine.
`timescale 1ns / 1ps

package bf_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 10;
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int ROUNDS    = 16;
    localparam int SUBKEYS   = ROUNDS + 2;
    localparam int KEY_IDX_W = $clog2(SUBKEYS);
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam int NUM_BOX   = 4;
    localparam int BOX_DEPTH = 256;
    localparam int BOX_SEL_W = $clog2(NUM_BOX);
    localparam int BOX_AW    = $clog2(BOX_DEPTH);

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_KEY  = 2'd0,
        CMD_WR_SBOX = 2'd1,
        CMD_ENC     = 2'd2,
        CMD_DEC     = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_ROUND = 1'b1
    } t_state;

    // F(x) from the four looked-up words: ((S0 + S1) ^ S2) + S3, mod 2^32
    function automatic t_word bf_round_f(input t_word s0, input t_word s1,
                                         input t_word s2, input t_word s3);
        t_word sum01;
        sum01 = s0 + s1;
        return (sum01 ^ s2) + s3;
    endfunction

endpackage

// File: rtl/bf_if.sv
// Stream interfaces for the command channel and the result channel.
`timescale 1ns / 1ps

interface bf_in_if;
    import bf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [IDX_W-1:0]     table_index;
    logic [WORD_W-1:0]    table_word;
    logic [WORD_W-1:0]    left_half;
    logic [WORD_W-1:0]    right_half;
    logic                 last_block;

    modport source (output valid, cmd, table_index, table_word, left_half, right_half,
                    last_block, input ready);
    modport sink   (input valid, cmd, table_index, table_word, left_half, right_half,
                    last_block, output ready);
endinterface

interface bf_out_if;
    import bf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    left_out;
    logic [WORD_W-1:0]    right_out;
    logic                 last_out;

    modport source (output valid, left_out, right_out, last_out, input ready);
    modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

// File: rtl/blowfish_block_cipher_top.sv
// Throughput: one table load per cycle while idle; no transaction is taken until a cipher
//   block has run its rounds, one Feistel round per cycle through the registered read
//   ports of the four S-box RAMs; the last round waits on a full output register.
// A finished result waits in the output register while the next transaction is taken.
// Reset (synchronous, active low) clears the control state only; the subkey and S-box
//   tables hold no defined value until software loads them.
`timescale 1ns / 1ps

module blowfish_block_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bf_in_if.sink       i_in,
    bf_out_if.source    o_out
);
    import bf_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [ROUND_W-1:0]    r_round;
    logic                  r_dec;
    logic                  r_last;
    t_word                 r_xl;
    t_word                 r_xr;
    t_word                 r_subkey [SUBKEYS];
    t_word                 r_sbox_rd [NUM_BOX];

    logic                  r_out_valid;
    t_word                 r_out_l;
    t_word                 r_out_r;
    logic                  r_out_last;

    logic                  in_ready;
    logic                  in_acc;
    t_cmd                  in_cmd;
    logic                  start;
    logic                  last_round;
    logic                  out_free;
    logic                  advance;
    logic                  rd_en;
    t_word                 rd_addr;
    t_word                 key0;
    t_word                 f_val;
    t_word                 xr_new;
    t_word                 xl_next;
    logic [KEY_IDX_W-1:0]  key_idx;
    logic                  key_wr;
    logic                  sbox_wr;

    assign in_acc     = i_in.valid && in_ready;
    assign in_cmd     = t_cmd'(i_in.cmd);
    assign start      = in_acc && (in_cmd == CMD_ENC || in_cmd == CMD_DEC);
    assign key_wr     = in_acc && (in_cmd == CMD_WR_KEY)
                        && (i_in.table_index < IDX_W'(SUBKEYS));
    assign sbox_wr    = in_acc && (in_cmd == CMD_WR_SBOX);
    assign last_round = (r_round == ROUND_W'(ROUNDS - 1));
    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = (r_state == ST_ROUND) && (!last_round || out_free);
    assign rd_en      = start || (advance && !last_round);

    // Key of the next round: encrypt walks up from P1, decrypt down from P16
    assign key_idx = r_dec ? (KEY_IDX_W'(SUBKEYS - 2) - KEY_IDX_W'(r_round))
                           : (KEY_IDX_W'(r_round) + KEY_IDX_W'(1));

    assign key0    = (in_cmd == CMD_DEC) ? r_subkey[SUBKEYS-1] : r_subkey[0];
    assign f_val   = bf_round_f(r_sbox_rd[0], r_sbox_rd[1], r_sbox_rd[2], r_sbox_rd[3]);
    assign xr_new  = r_xr ^ f_val;
    assign xl_next = xr_new ^ r_subkey[key_idx];
    assign rd_addr = start ? (i_in.left_half ^ key0) : xl_next;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_ROUND;
            ST_ROUND: if (advance && last_round) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        unique case (r_state)
            ST_IDLE:  in_ready = 1'b1;
            ST_ROUND: in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_round <= '0;
            end else if (advance) begin
                r_round <= r_round + ROUND_W'(1);
            end
            if (advance && last_round) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_xl   <= i_in.left_half ^ key0;
            r_xr   <= i_in.right_half;
            r_dec  <= (in_cmd == CMD_DEC);
            r_last <= i_in.last_block;
        end else if (advance && !last_round) begin
            r_xl <= xl_next;
            r_xr <= r_xl;
        end
        // Final round undoes the last swap and applies the output whitening keys
        if (advance && last_round) begin
            r_out_l    <= r_xl ^ (r_dec ? r_subkey[0] : r_subkey[SUBKEYS-1]);
            r_out_r    <= xr_new ^ (r_dec ? r_subkey[1] : r_subkey[SUBKEYS-2]);
            r_out_last <= r_last;
        end
        if (key_wr) begin
            r_subkey[i_in.table_index[KEY_IDX_W-1:0]] <= i_in.table_word;
        end
    end

    // One 256-entry RAM per S-box, byte lane 3-b of the half addresses box b
    for (genvar b = 0; b < NUM_BOX; b++) begin : g_sbox
        t_word r_mem [BOX_DEPTH];

        always_ff @(posedge i_clk) begin
            if (sbox_wr && (i_in.table_index[IDX_W-1 -: BOX_SEL_W] == BOX_SEL_W'(b))) begin
                r_mem[i_in.table_index[BOX_AW-1:0]] <= i_in.table_word;
            end
            if (rd_en) begin
                r_sbox_rd[b] <= r_mem[rd_addr[BYTE_W*(NUM_BOX-1-b) +: BYTE_W]];
            end
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;
    assign o_out.last_out  = r_out_last;

`ifndef SYNTHESIS
    a_idle_round_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_round == '0))
        else $error("round counter not cleared while idle");

    a_cipher_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !i_in.ready)
        else $error("input still ready after a cipher transaction was taken");

    a_result_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |->
            ($past(r_state) == ST_ROUND && $past(r_round) == ROUND_W'(ROUNDS - 1)))
        else $error("result appeared without finishing the last round");

    a_stall_holds_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && last_round && !out_free) |=>
            (r_state == ST_ROUND && last_round))
        else $error("last round left while the output register was full");
`endif

endmodule
